/* hdl/audit_event_log_engine_unit_defines.svh */
// Assertion macros used by the audit event log datapath.
`ifndef AUDIT_EVENT_LOG_ENGINE_UNIT_DEFINES_SVH
`define AUDIT_EVENT_LOG_ENGINE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AEL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AEL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ael_pkg.sv */
// Shared types, codes and constants of the audit event log.
package ael_pkg;

  localparam int LOG_DEPTH_DEF = 32;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_MARK   = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NF   = 2'd3;

  localparam logic [1:0] SEL_NONE  = 2'd0;
  localparam logic [1:0] SEL_ADD   = 2'd1;
  localparam logic [1:0] SEL_MARK  = 2'd2;
  localparam logic [1:0] SEL_FOUND = 2'd3;

  localparam logic [1:0] CFG_SEV_MASK   = 2'd0;
  localparam logic [1:0] CFG_AUTO_CLEAN = 2'd1;
  localparam logic [1:0] CFG_OVF_STOP   = 2'd2;

  localparam int UNLOADED_BIT = 7;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] ts;
    logic [15:0] evt;
    logic [7:0]  usr;
    logic [7:0]  sev;
    logic [7:0]  flg;
  } rec_t;

  typedef struct packed {
    logic       load;
    logic       scan_start;
    logic       scan_run;
    logic       rd_head;
    logic       id_fix;
    logic       id_bump;
    logic       finish;
    logic [1:0] fin_sel;
    logic [1:0] fin_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       add_skip;
    logic       add_stop;
    logic       full;
    logic       full_block;
    logic       empty;
    logic       abort;
    logic       scan_done;
    logic       hit;
    logic       out_free;
  } dp_stat_t;

endpackage

/* hdl/ael_ctrl.sv */
// Controller state machine of the audit event log.
module ael_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ael_pkg::dp_stat_t  st,
  output ael_pkg::ctrl_cmd_t cmd
);
  import ael_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_ASCAN = 3'd2;
  localparam logic [2:0] S_MSCAN = 3'd3;
  localparam logic [2:0] S_SSCAN = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state, state_next;
  logic [1:0] sel, sel_next;
  logic [1:0] fstat, fstat_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= SEL_NONE;
      fstat <= ST_DONE;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      fstat <= fstat_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    sel_next   = sel;
    fstat_next = fstat;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        case (st.act)
          ACT_ADD: begin
            if (st.add_skip) begin
              fstat_next = ST_SKIP;
              sel_next   = SEL_NONE;
              state_next = S_FIN;
            end else if (st.add_stop || (st.full && st.full_block)) begin
              fstat_next = ST_FULL;
              sel_next   = SEL_NONE;
              state_next = S_FIN;
            end else begin
              cmd.id_fix     = 1'b1;
              cmd.scan_start = 1'b1;
              state_next     = S_ASCAN;
            end
          end
          ACT_MARK: begin
            if (st.abort) begin
              fstat_next = ST_NF;
              sel_next   = SEL_NONE;
              state_next = S_FIN;
            end else if (st.empty) begin
              fstat_next = ST_DONE;
              sel_next   = SEL_NONE;
              state_next = S_FIN;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_MSCAN;
            end
          end
          ACT_SEARCH: begin
            cmd.scan_start = 1'b1;
            state_next     = S_SSCAN;
          end
          default: begin
            fstat_next = ST_NF;
            sel_next   = SEL_NONE;
            state_next = S_FIN;
          end
        endcase
      end
      S_ASCAN: begin
        // A candidate ID in use moves the counter on and restarts the scan.
        if (st.hit) begin
          cmd.id_bump    = 1'b1;
          cmd.scan_start = 1'b1;
        end else if (st.scan_done) begin
          cmd.rd_head = st.full;
          fstat_next  = ST_DONE;
          sel_next    = SEL_ADD;
          state_next  = S_FIN;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      S_MSCAN: begin
        if (st.hit) begin
          fstat_next = ST_DONE;
          sel_next   = SEL_MARK;
          state_next = S_FIN;
        end else if (st.scan_done) begin
          fstat_next = ST_NF;
          sel_next   = SEL_NONE;
          state_next = S_FIN;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      S_SSCAN: begin
        if (st.hit) begin
          fstat_next = ST_DONE;
          sel_next   = SEL_FOUND;
          state_next = S_FIN;
        end else if (st.scan_done) begin
          fstat_next = ST_NF;
          sel_next   = SEL_NONE;
          state_next = S_FIN;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.finish     = 1'b1;
          cmd.fin_sel    = sel;
          cmd.fin_status = fstat;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/ael_dpath.sv */
// Datapath of the audit event log: record memory, scan engine and result register.
`include "audit_event_log_engine_unit_defines.svh"
module ael_dpath #(
  parameter int LOG_DEPTH = ael_pkg::LOG_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ael_pkg::ctrl_cmd_t cmd,
  output ael_pkg::dp_stat_t  st,
  input  logic [1:0]         action,
  input  logic [7:0]         user_id,
  input  logic [15:0]        event_code,
  input  logic [7:0]         severity,
  input  logic [7:0]         record_flags,
  input  logic [31:0]        timestamp,
  input  logic [31:0]        record_id,
  input  logic               batch_last,
  input  logic [6:0]         field_mask,
  input  logic [31:0]        search_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [4:0]         hit_index,
  output logic [31:0]        hit_record_id,
  output logic [31:0]        hit_timestamp,
  output logic [15:0]        hit_event_code,
  output logic [7:0]         hit_user_id,
  output logic [7:0]         hit_severity,
  output logic [7:0]         hit_flags,
  output logic [5:0]         pending_count
);
  import ael_pkg::*;

  localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int CNT_W = $clog2(LOG_DEPTH + 1);
  localparam logic [IDX_W:0]   DEPTH_P = (IDX_W + 1)'(LOG_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LOG_DEPTH);

  rec_t mem [LOG_DEPTH];

  // Configuration registers.
  logic [7:0] sev_mask;
  logic       auto_clean;
  logic       ovf_stop;

  // Latched transaction.
  logic [1:0]  act_q;
  logic [7:0]  usr_q;
  logic [15:0] evt_q;
  logic [7:0]  sev_q;
  logic [7:0]  flg_q;
  logic [31:0] ts_q;
  logic [31:0] rid_q;
  logic        blast_q;
  logic [6:0]  fmask_q;
  logic [31:0] sval_q;

  // Log state. Records live in a ring starting at head.
  logic [IDX_W-1:0] head;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] pending;
  logic [31:0]      next_id;
  logic             abort;

  // Scan engine.
  logic [CNT_W-1:0] scan_i;
  logic             cmp_v;
  logic [IDX_W-1:0] cmp_pos;
  logic [IDX_W-1:0] cmp_phys;
  rec_t             rd_q;

  logic [IDX_W:0]   sum_i, sum_c;
  logic [IDX_W-1:0] phys_i, phys_c, head_inc;
  logic             full, issue, rd_en, match, srch_hit;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      nid_inc;
  logic [CNT_W-1:0] pend_nxt, add_pos;
  logic             we;
  logic [IDX_W-1:0] wr_addr;
  rec_t             new_rec, mark_rec, wr_data, res_rec;
  logic [4:0]       res_idx;

  assign full     = (count == DEPTH_C);
  assign sum_i    = {1'b0, head} + (IDX_W + 1)'(scan_i);
  assign phys_i   = (sum_i >= DEPTH_P) ? IDX_W'(sum_i - DEPTH_P) : IDX_W'(sum_i);
  assign sum_c    = {1'b0, head} + (IDX_W + 1)'(count);
  assign phys_c   = (sum_c >= DEPTH_P) ? IDX_W'(sum_c - DEPTH_P) : IDX_W'(sum_c);
  assign head_inc = (head == IDX_W'(LOG_DEPTH - 1)) ? '0 : head + 1'b1;
  assign issue    = cmd.scan_run && (scan_i < count);
  assign rd_en    = issue || cmd.rd_head;
  assign rd_addr  = cmd.rd_head ? head : phys_i;
  assign nid_inc  = next_id + 32'd1;

  always_comb begin
    srch_hit = (fmask_q[0] && (rd_q.id == sval_q)) ||
               (fmask_q[1] && (rd_q.ts == sval_q)) ||
               (fmask_q[2] && (rd_q.evt == sval_q[15:0])) ||
               (fmask_q[3] && (rd_q.usr == sval_q[7:0])) ||
               (fmask_q[4] && (rd_q.sev == sval_q[7:0])) ||
               (fmask_q[5] && (rd_q.flg == sval_q[7:0])) ||
               (fmask_q[6] && (32'(cmp_pos) == sval_q));
    case (act_q)
      ACT_ADD:    match = (rd_q.id == next_id);
      ACT_MARK:   match = (rd_q.id == rid_q);
      ACT_SEARCH: match = srch_hit;
      default:    match = 1'b0;
    endcase
  end

  always_comb begin
    st.act        = act_q;
    st.add_skip   = (usr_q == 8'd0) || ((sev_q & sev_mask) == 8'd0);
    st.add_stop   = ovf_stop;
    st.full       = full;
    st.full_block = (pending == count) || !auto_clean;
    st.empty      = (count == '0);
    st.abort      = abort;
    st.scan_done  = (scan_i == count) && !cmp_v;
    st.hit        = cmp_v && match;
    st.out_free   = !out_valid || !out_stall;
  end

  always_comb begin
    new_rec.id  = next_id;
    new_rec.ts  = ts_q;
    new_rec.evt = evt_q;
    new_rec.usr = usr_q;
    new_rec.sev = sev_q;
    new_rec.flg = {1'b0, flg_q[6:0]};
    mark_rec    = rd_q;
    mark_rec.flg[UNLOADED_BIT] = 1'b1;
    add_pos     = count - CNT_W'(full);
    we          = 1'b0;
    wr_addr     = phys_c;
    wr_data     = new_rec;
    pend_nxt    = pending;
    res_rec     = '0;
    res_idx     = '0;
    case (cmd.fin_sel)
      SEL_ADD: begin
        we  = cmd.finish;
        // On a full log rd_q holds the oldest record, which is overwritten.
        pend_nxt = pending + CNT_W'(1) - CNT_W'(full && !rd_q.flg[UNLOADED_BIT]);
        res_rec  = new_rec;
        res_idx  = 5'(add_pos);
      end
      SEL_MARK: begin
        we       = cmd.finish;
        wr_addr  = cmp_phys;
        wr_data  = mark_rec;
        pend_nxt = pending - CNT_W'(!rd_q.flg[UNLOADED_BIT]);
        res_rec  = mark_rec;
        res_idx  = 5'(cmp_pos);
      end
      SEL_FOUND: begin
        res_rec = rd_q;
        res_idx = 5'(cmp_pos);
      end
      default: begin
        res_rec = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sev_mask   <= 8'hFF;
      auto_clean <= 1'b0;
      ovf_stop   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEV_MASK:   sev_mask   <= cfg_data;
        CFG_AUTO_CLEAN: auto_clean <= cfg_data[0];
        CFG_OVF_STOP:   ovf_stop   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q   <= action;
      usr_q   <= user_id;
      evt_q   <= event_code;
      sev_q   <= severity;
      flg_q   <= record_flags;
      ts_q    <= timestamp;
      rid_q   <= record_id;
      blast_q <= batch_last;
      fmask_q <= field_mask;
      sval_q  <= search_value;
    end
    if (issue) begin
      cmp_pos  <= scan_i[IDX_W-1:0];
      cmp_phys <= phys_i;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_i <= '0;
      cmp_v  <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_i <= '0;
      cmp_v  <= 1'b0;
    end else if (cmd.scan_run) begin
      cmp_v <= issue;
      if (issue) begin
        scan_i <= scan_i + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      pending <= '0;
      next_id <= '0;
      abort   <= 1'b0;
    end else begin
      if (cmd.id_fix && (next_id == 32'd0)) begin
        next_id <= 32'd1;
      end else if (cmd.id_bump) begin
        next_id <= (nid_inc == 32'd0) ? 32'd1 : nid_inc;
      end else if (cmd.finish && (cmd.fin_sel == SEL_ADD)) begin
        next_id <= nid_inc;
      end
      if (cmd.finish) begin
        pending <= pend_nxt;
        if (cmd.fin_sel == SEL_ADD) begin
          if (full) begin
            head <= head_inc;
          end else begin
            count <= count + 1'b1;
          end
        end
        if ((act_q == ACT_ADD) || (act_q == ACT_SEARCH)) begin
          abort <= 1'b0;
        end else if (act_q == ACT_MARK) begin
          abort <= blast_q ? 1'b0 : (abort || (cmd.fin_status == ST_NF));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status         <= cmd.fin_status;
      hit_index      <= res_idx;
      hit_record_id  <= res_rec.id;
      hit_timestamp  <= res_rec.ts;
      hit_event_code <= res_rec.evt;
      hit_user_id    <= res_rec.usr;
      hit_severity   <= res_rec.sev;
      hit_flags      <= res_rec.flg;
      pending_count  <= 6'(pend_nxt);
    end
  end

  `AEL_ASSERT_IMP(a_count_max, 1'b1, count <= DEPTH_C, "record count above depth")
  `AEL_ASSERT_IMP(a_pend_le_count, 1'b1, pending <= count, "pending above record count")
  `AEL_ASSERT_IMP(a_add_id_nonzero, cmd.finish && (cmd.fin_sel == SEL_ADD), next_id != 32'd0, "zero ID stored")
  `AEL_ASSERT_NXT(a_add_nonempty, cmd.finish && (cmd.fin_sel == SEL_ADD), (count != '0) && out_valid, "add left log empty")

endmodule

/* hdl/audit_event_log_engine_unit.sv */
// Top level of the audit event log: controller, datapath and configuration port.
// Audit event log of LOG_DEPTH records held in one ring memory with a single
// read port. An add walks the stored records, one record read per cycle, to
// check that the next ID is free; each ID already in the log moves the ID on
// and restarts the walk. A mark or a search walks the records in order and
// stops at the first hit. Skipped, rejected and aborted transactions end
// without walking the stored records.
// One transaction is in progress at a time; the result register lets the next
// one be taken while the previous result waits. The configuration port is
// always ready and must be written only while the log is idle.
module audit_event_log_engine_unit #(
  parameter int LOG_DEPTH = ael_pkg::LOG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [7:0]  user_id,
  input  logic [15:0] event_code,
  input  logic [7:0]  severity,
  input  logic [7:0]  record_flags,
  input  logic [31:0] timestamp,
  input  logic [31:0] record_id,
  input  logic        batch_last,
  input  logic [6:0]  field_mask,
  input  logic [31:0] search_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [4:0]  hit_index,
  output logic [31:0] hit_record_id,
  output logic [31:0] hit_timestamp,
  output logic [15:0] hit_event_code,
  output logic [7:0]  hit_user_id,
  output logic [7:0]  hit_severity,
  output logic [7:0]  hit_flags,
  output logic [5:0]  pending_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import ael_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  st;

  assign cfg_ready = 1'b1;

  ael_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ael_dpath #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .action         (action),
    .user_id        (user_id),
    .event_code     (event_code),
    .severity       (severity),
    .record_flags   (record_flags),
    .timestamp      (timestamp),
    .record_id      (record_id),
    .batch_last     (batch_last),
    .field_mask     (field_mask),
    .search_value   (search_value),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .hit_index      (hit_index),
    .hit_record_id  (hit_record_id),
    .hit_timestamp  (hit_timestamp),
    .hit_event_code (hit_event_code),
    .hit_user_id    (hit_user_id),
    .hit_severity   (hit_severity),
    .hit_flags      (hit_flags),
    .pending_count  (pending_count)
  );

endmodule
